### hdl/i2cm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared command codes, phase codes and the transfer records between the
// input stage, the sequencer core and the result stage.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_WAIT  = 3'd3,
        CMD_READ  = 3'd4,
        CMD_IDLE  = 3'd7
    } cmd_t;

    localparam logic [2:0] PH_REST     = 3'd0;
    localparam logic [2:0] PH_FIRST    = 3'd1;
    localparam logic [2:0] PH_SECOND   = 3'd2;
    localparam logic [2:0] PH_ACK_HIGH = 3'd3;
    localparam logic [2:0] PH_ACK_LOW  = 3'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] TIMEOUT_RESET = 8'd250;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } res_t;

endpackage : i2cm_pkg
`default_nettype wire

### hdl/i2cm_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer core
// Holds the bus sequencing state and advances it by one half-bit tick each
// cycle that step_en is high, producing the result of that tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire i2cm_pkg::tick_t tick,
    input  wire logic [7:0]    ack_limit,
    output i2cm_pkg::res_t     res
);
    import i2cm_pkg::*;

    cmd_t       cmd_reg, cmd_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_reg, poll_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drive_reg, drive_next;
    logic [7:0] rx_reg, rx_next;
    logic       ack_reg, ack_next;
    logic       read_ack_reg, read_ack_next;
    logic       done;

    // Next state for one tick.
    always_comb begin
        cmd_next      = cmd_reg;
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        poll_next     = poll_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        drive_next    = drive_reg;
        rx_next       = rx_reg;
        ack_next      = ack_reg;
        read_ack_next = read_ack_reg;
        done          = 1'b0;

        if (cmd_reg == CMD_IDLE) begin
            if (tick.cmd_valid && (tick.mode <= 3'(CMD_READ))) begin
                cmd_next   = cmd_t'(tick.mode);
                phase_next = PH_FIRST;
                ack_next   = 1'b0;
                case (cmd_t'(tick.mode))
                    CMD_START: begin
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                    end
                    CMD_STOP: begin
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    CMD_WRITE: begin
                        drive_next   = 1'b1;
                        scl_next     = 1'b0;
                        shift_next   = tick.tx_byte;
                        sda_next     = tick.tx_byte[7];
                        bit_cnt_next = '0;
                    end
                    CMD_WAIT: begin
                        drive_next = 1'b0;
                        sda_next   = 1'b1;
                        poll_next  = '0;
                    end
                    default: begin
                        drive_next    = 1'b0;
                        sda_next      = 1'b1;
                        scl_next      = 1'b0;
                        shift_next    = '0;
                        bit_cnt_next  = '0;
                        read_ack_next = tick.ack_after_read;
                    end
                endcase
            end
        end else begin
            case (cmd_reg)
                CMD_START: begin
                    if (phase_reg == PH_FIRST) begin
                        sda_next   = 1'b0;
                        phase_next = PH_SECOND;
                    end else begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (phase_reg == PH_FIRST) begin
                        scl_next   = 1'b1;
                        phase_next = PH_SECOND;
                    end else begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (phase_reg == PH_FIRST) begin
                        scl_next   = 1'b1;
                        phase_next = PH_SECOND;
                    end else begin
                        scl_next     = 1'b0;
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        if (bit_cnt_next >= BITS_PER_BYTE) begin
                            done = 1'b1;
                        end else begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            sda_next   = shift_reg[6];
                            phase_next = PH_FIRST;
                        end
                    end
                end
                CMD_WAIT: begin
                    if (phase_reg == PH_FIRST) begin
                        scl_next   = 1'b1;
                        phase_next = PH_SECOND;
                    end else if (!tick.sda_in) begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end else if (poll_reg >= ack_limit) begin
                        // No acknowledge in time: fall into a stop sequence.
                        ack_next   = 1'b1;
                        cmd_next   = CMD_STOP;
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_FIRST;
                    end else begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                default: begin
                    if (phase_reg == PH_FIRST) begin
                        scl_next     = 1'b1;
                        shift_next   = {shift_reg[6:0], tick.sda_in};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        phase_next   = PH_SECOND;
                    end else if (phase_reg == PH_SECOND) begin
                        scl_next = 1'b0;
                        if (bit_cnt_reg >= BITS_PER_BYTE) begin
                            drive_next = 1'b1;
                            sda_next   = !read_ack_reg;
                            phase_next = PH_ACK_HIGH;
                        end else begin
                            phase_next = PH_FIRST;
                        end
                    end else if (phase_reg == PH_ACK_HIGH) begin
                        scl_next   = 1'b1;
                        phase_next = PH_ACK_LOW;
                    end else begin
                        scl_next = 1'b0;
                        rx_next  = shift_reg;
                        done     = 1'b1;
                    end
                end
            endcase
            if (done) begin
                cmd_next   = CMD_IDLE;
                phase_next = PH_REST;
            end
        end
    end

    // Result of the tick, taken from the updated state.
    always_comb begin
        res.scl_level   = scl_next;
        res.sda_level   = drive_next ? sda_next : 1'b1;
        res.sda_drive   = drive_next;
        res.busy        = (cmd_next != CMD_IDLE);
        res.done        = done;
        res.rx_byte     = rx_next;
        res.ack_missing = ack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg      <= CMD_IDLE;
            phase_reg    <= PH_REST;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            poll_reg     <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            drive_reg    <= 1'b1;
            rx_reg       <= '0;
            ack_reg      <= 1'b0;
            read_ack_reg <= 1'b0;
        end else if (step_en) begin
            cmd_reg      <= cmd_next;
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            poll_reg     <= poll_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            drive_reg    <= drive_next;
            rx_reg       <= rx_next;
            ack_reg      <= ack_next;
            read_ack_reg <= read_ack_next;
        end
    end

`ifndef SYNTHESIS
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && res.done) |=> (cmd_reg == CMD_IDLE))
        else $error("sequencer not idle after a completed command");

    a_ack_from_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ack_reg) |-> ($past(cmd_reg) == CMD_WAIT))
        else $error("missing acknowledge flagged outside wait");

    a_bit_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg <= BITS_PER_BYTE)
        else $error("bit counter past one byte");

    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg == CMD_IDLE) == (phase_reg == PH_REST))
        else $error("phase and command disagree on idle");
`endif

endmodule : i2cm_seq
`default_nettype wire

### hdl/i2c_master_bit_sequencer_top.sv
// A tick in the input register is processed when it advances, and its result
// is then offered on the m_ channel. Throughput: one tick per cycle while
// m_ready is high; a waiting result holds at most one tick in the input
// register, and s_ready drops only when both registers are full.
// Reset (aresetn low at a clock edge): bus lines idle high with SDA driven,
// no command active, timeout limit back to 250, both channels empty.
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer, top level
// Input tick register, sequencer core, result register and the timeout
// limit register.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_cmd_valid,
    input  wire logic [2:0] s_mode,
    input  wire logic [7:0] s_tx_byte,
    input  wire logic       s_ack_after_read,
    input  wire logic       s_sda_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_scl_level,
    output logic            m_sda_level,
    output logic            m_sda_drive,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic [7:0]      m_rx_byte,
    output logic            m_ack_missing,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);
    import i2cm_pkg::*;

    logic       in_vld_reg;
    tick_t      in_reg;
    logic       out_vld_reg;
    res_t       out_reg;
    logic [7:0] limit_reg;
    res_t       step_res;
    logic       advance;

    // A tick moves into the result register when that register is free or
    // is being emptied in the same cycle.
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            limit_reg   <= TIMEOUT_RESET;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= '{cmd_valid: s_cmd_valid, mode: s_mode, tx_byte: s_tx_byte,
                        ack_after_read: s_ack_after_read, sda_in: s_sda_in};
        end
        if (advance) begin
            out_reg <= step_res;
        end
    end

    i2cm_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .tick      (in_reg),
        .ack_limit (limit_reg),
        .res       (step_res)
    );

    assign m_valid       = out_vld_reg;
    assign m_scl_level   = out_reg.scl_level;
    assign m_sda_level   = out_reg.sda_level;
    assign m_sda_drive   = out_reg.sda_drive;
    assign m_busy_res    = out_reg.busy;
    assign m_done_res    = out_reg.done;
    assign m_rx_byte     = out_reg.rx_byte;
    assign m_ack_missing = out_reg.ack_missing;

endmodule : i2c_master_bit_sequencer_top
`default_nettype wire
